/* rtl/fse_pkg.sv */
// Shared types and constants for the firmware sysex block encoder.
// No dependencies; every rtl file imports this package.
`default_nettype none
package fse_pkg;

  localparam logic [7:0] SYSEX_START = 8'hF0;
  localparam logic [7:0] SYSEX_END   = 8'hF7;
  localparam logic [7:0] PAD_BYTE    = 8'hFF;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;
  localparam int POS_W      = 7;
  localparam int ADDR_W     = 28;
  localparam int SEQ_W      = 4;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_VENDOR_FIRST  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VENDOR_SECOND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_NUMBER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_OPCODE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SUM_OPCODE    = 3'd4;

  typedef enum logic [1:0] {
    CMD_DATA = 2'd0,
    CMD_PAD  = 2'd1,
    CMD_END  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [6:0] vendor_first;
    logic [6:0] vendor_second;
    logic [6:0] device_number;
    logic [6:0] block_opcode;
    logic [6:0] sum_opcode;
  } cfg_t;

  // One queued item: which segments to send plus the data they need.
  typedef struct packed {
    logic              is_end;
    logic              head;
    logic [2:0]        n_grp;
    logic              close;
    logic [6:0]        top;
    logic [6:0][6:0]   grp;
    logic [6:0]        xsum;
    logic [ADDR_W-1:0] addr;
    logic [15:0]       len;
    logic [15:0]       sum;
  } job_t;

endpackage
`default_nettype wire

/* rtl/fse_front.sv */
// Front end: accepts items, tracks block/group state, builds jobs.
// Depends on fse_pkg.
`default_nettype none
module fse_front #(
  parameter int BLOCK_BYTES = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire fse_pkg::cfg_t cfg,
  input  wire logic         acc,
  input  wire logic [1:0]   command,
  input  wire logic [7:0]   data_byte,
  output logic              push,
  output fse_pkg::job_t     job
);
  import fse_pkg::*;

  localparam logic [POS_W-1:0] POS_LAST = POS_W'(BLOCK_BYTES - 1);
  localparam logic [6:0]       BB7      = 7'(BLOCK_BYTES);

  logic [POS_W-1:0]  pos_r;
  logic [2:0]        slot_r;
  logic [6:0]        top_r;
  logic [6:0]        xor_r;
  logic [ADDR_W-1:0] addr_r;
  logic [15:0]       len_r;
  logic [15:0]       sum_r;
  logic              fin_r;
  logic [6:0][6:0]   grp_r;

  logic [7:0]   b;
  logic         head, grp6, close, blk, endi;
  logic [6:0]   xbase, x1, xfin, top_new;
  logic [2:0]   n;
  logic [6:0][6:0] grp_snap;

  always_comb begin
    endi = acc && !fin_r && (command == CMD_END);
    blk  = acc && !fin_r && ((command == CMD_DATA) || (command == CMD_PAD));
    b    = (command == CMD_DATA) ? data_byte : PAD_BYTE;
    head = (pos_r == '0);
    xbase = head ? (cfg.block_opcode ^ BB7 ^ addr_r[6:0] ^ addr_r[13:7]
                    ^ addr_r[20:14] ^ addr_r[27:21]) : xor_r;
    x1 = xbase ^ b[6:0];
    top_new = top_r | (7'(b[7]) << slot_r);
    grp6  = (slot_r == 3'd6);
    close = (pos_r == POS_LAST);
    n = grp6 ? 3'd7 : (close ? slot_r + 3'd1 : 3'd0);
    xfin = (n != 3'd0) ? (x1 ^ top_new) : x1;
    grp_snap = grp_r;
    grp_snap[slot_r] = b[6:0];

    job.is_end = endi;
    job.head   = head;
    job.n_grp  = n;
    job.close  = close;
    job.top    = top_new;
    job.grp    = grp_snap;
    job.xsum   = xfin;
    job.addr   = addr_r;
    job.len    = len_r;
    job.sum    = sum_r;
    push = endi || (blk && (head || (n != 3'd0) || close));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      slot_r <= '0;
      top_r  <= '0;
      xor_r  <= '0;
      addr_r <= '0;
      len_r  <= '0;
      sum_r  <= '0;
      fin_r  <= 1'b0;
    end else if (endi) begin
      fin_r  <= 1'b1;
      pos_r  <= '0;
      slot_r <= '0;
      top_r  <= '0;
      xor_r  <= '0;
    end else if (blk) begin
      top_r  <= (n != 3'd0) ? 7'd0 : top_new;
      xor_r  <= close ? 7'd0 : xfin;
      pos_r  <= close ? '0 : pos_r + POS_W'(1);
      slot_r <= (close || grp6) ? 3'd0 : slot_r + 3'd1;
      if (close) addr_r <= addr_r + ADDR_W'(BLOCK_BYTES);
      if (command == CMD_DATA) begin
        len_r <= len_r + 16'd1;
        sum_r <= sum_r + {8'd0, data_byte};
      end
    end
  end

  // group store has no reset: every entry is written before it is sent
  always_ff @(posedge clk) begin
    if (blk) grp_r[slot_r] <= b[6:0];
  end

endmodule
`default_nettype wire

/* rtl/fse_queue.sv */
// Small register FIFO of jobs between front and back end.
// Depends on fse_pkg.
`default_nettype none
module fse_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire fse_pkg::job_t wr_job,
  input  wire logic          pop,
  output fse_pkg::job_t      rd_job,
  output logic               empty,
  output logic               full
);
  import fse_pkg::*;

  job_t           q_r [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0]   cnt_r;

  assign empty  = (cnt_r == '0);
  assign full   = (cnt_r == (QAW+1)'(QDEPTH));
  assign rd_job = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + QAW'(1);
      if (pop)  rp_r <= rp_r + QAW'(1);
      if (push && !pop)      cnt_r <= cnt_r + (QAW+1)'(1);
      else if (pop && !push) cnt_r <= cnt_r - (QAW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= wr_job;
  end

endmodule
`default_nettype wire

/* rtl/fse_back.sv */
// Back end: walks the head job one byte per beat into the output register.
// Depends on fse_pkg.
`default_nettype none
module fse_back #(
  parameter int BLOCK_BYTES = 64
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire fse_pkg::cfg_t cfg,
  input  wire fse_pkg::job_t job,
  input  wire logic          empty,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [7:0]         out_byte,
  output logic               out_last_of_run,
  output logic               out_message_end
);
  import fse_pkg::*;

  localparam logic [6:0] BB7 = 7'(BLOCK_BYTES);

  logic [SEQ_W-1:0] p_r;
  logic             ov_r;
  logic [7:0]       ob_r;
  logic             ol_r, oe_r;

  logic [SEQ_W-1:0] hlen, glen, total, q, r;
  logic [7:0]       byte_c;
  logic             last_c, mend_c, adv;
  logic [6:0]       f5, f6, f7, f8, f9, opc;

  always_comb begin
    hlen  = job.head ? SEQ_W'(10) : SEQ_W'(0);
    glen  = (job.n_grp != 3'd0) ? SEQ_W'(job.n_grp) + SEQ_W'(1) : SEQ_W'(0);
    total = job.is_end ? SEQ_W'(11)
                       : hlen + glen + (job.close ? SEQ_W'(2) : SEQ_W'(0));
    q = p_r - hlen;
    r = q - glen;
    opc = job.is_end ? cfg.sum_opcode : cfg.block_opcode;
    f5  = job.is_end ? job.len[6:0]          : BB7;
    f6  = job.is_end ? job.len[13:7]         : job.addr[6:0];
    f7  = job.is_end ? {5'd0, job.len[15:14]} : job.addr[13:7];
    f8  = job.is_end ? job.sum[6:0]          : job.addr[20:14];
    f9  = job.is_end ? job.sum[13:7]         : job.addr[27:21];
    mend_c = 1'b0;
    if (job.is_end || p_r < hlen) begin
      case (p_r)
        4'd0:    byte_c = SYSEX_START;
        4'd1:    byte_c = {1'b0, cfg.vendor_first};
        4'd2:    byte_c = {1'b0, cfg.vendor_second};
        4'd3:    byte_c = {1'b0, cfg.device_number};
        4'd4:    byte_c = {1'b0, opc};
        4'd5:    byte_c = {1'b0, f5};
        4'd6:    byte_c = {1'b0, f6};
        4'd7:    byte_c = {1'b0, f7};
        4'd8:    byte_c = {1'b0, f8};
        4'd9:    byte_c = {1'b0, f9};
        default: begin
          byte_c = SYSEX_END;
          mend_c = 1'b1;
        end
      endcase
    end else if (q < glen) begin
      byte_c = (q == '0) ? {1'b0, job.top} : {1'b0, job.grp[3'(q - SEQ_W'(1))]};
    end else if (r == '0) begin
      byte_c = {1'b0, job.xsum};
    end else begin
      byte_c = SYSEX_END;
      mend_c = 1'b1;
    end
    last_c = (p_r == total - SEQ_W'(1));
    adv    = !ov_r || !out_stall;
    pop    = adv && !empty && last_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r  <= '0;
      ov_r <= 1'b0;
    end else if (adv) begin
      ov_r <= !empty;
      if (!empty) p_r <= last_c ? '0 : p_r + SEQ_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (adv && !empty) begin
      ob_r <= byte_c;
      ol_r <= last_c;
      oe_r <= mend_c;
    end
  end

  assign out_valid       = ov_r;
  assign out_byte        = ob_r;
  assign out_last_of_run = ol_r;
  assign out_message_end = oe_r;

endmodule
`default_nettype wire

/* rtl/firmware_sysex_block_encoder.sv */
// Top level of the firmware sysex block encoder: config registers, front,
// job queue and back end. Depends on fse_pkg, fse_front, fse_queue, fse_back.
//
//   channel | ports                                   | direction
//   in      | in_valid in_stall in_command in_data_byte | item in
//   out     | out_valid out_stall out_byte              | byte out
//           | out_last_of_run out_message_end           |
//   cfg     | cfg_we cfg_index cfg_data                 | write only
//
// The front takes one item per cycle while the 4-entry job queue has room.
// The back sends one byte per cycle while out_stall is low; an item produces
// 0 to 11 bytes, about 1.34 bytes per item over a 64-byte block.
// Reset is synchronous; stall on the output only fills the queue, then in_stall.
`default_nettype none
module firmware_sysex_block_encoder #(
  parameter int BLOCK_BYTES = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [fse_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [fse_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [1:0]                       in_command,
  input  wire logic [7:0]                       in_data_byte,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [7:0]                            out_byte,
  output logic                                  out_last_of_run,
  output logic                                  out_message_end
);
  import fse_pkg::*;

  cfg_t cfg_r;
  job_t wr_job, rd_job;
  logic push, pop, empty, full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VENDOR_FIRST:  cfg_r.vendor_first  <= cfg_data;
        CFG_VENDOR_SECOND: cfg_r.vendor_second <= cfg_data;
        CFG_DEVICE_NUMBER: cfg_r.device_number <= cfg_data;
        CFG_BLOCK_OPCODE:  cfg_r.block_opcode  <= cfg_data;
        CFG_SUM_OPCODE:    cfg_r.sum_opcode    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = full;

  fse_front #(.BLOCK_BYTES(BLOCK_BYTES)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .acc       (in_valid && !in_stall),
    .command   (in_command),
    .data_byte (in_data_byte),
    .push      (push),
    .job       (wr_job)
  );

  fse_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .rd_job (rd_job),
    .empty  (empty),
    .full   (full)
  );

  fse_back #(.BLOCK_BYTES(BLOCK_BYTES)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .job             (rd_job),
    .empty           (empty),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run),
    .out_message_end (out_message_end)
  );

endmodule
`default_nettype wire
